// ----- hw/rtl/frustum_box_cull_core_defines.svh -----
// assertion helpers shared by the culling core
`ifndef FRUSTUM_BOX_CULL_CORE_DEFINES_SVH
`define FRUSTUM_BOX_CULL_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/fbc_pkg.sv -----
package fbc_pkg;

  localparam int ELEM_WIDTH  = 16;
  localparam int MATRIX_FRAC = 12;
  localparam int COORD_FRAC  = 8;

  localparam int COORD_WIDTH = 16;
  localparam int ROW_WIDTH   = 64;
  localparam int ROW_PAD     = (4 * ELEM_WIDTH > ROW_WIDTH) ? 4 * ELEM_WIDTH : ROW_WIDTH;
  localparam int COEF_WIDTH  = ELEM_WIDTH + 1;
  localparam int PROD_WIDTH  = COEF_WIDTH + COORD_WIDTH;
  localparam int DIST_WIDTH  = ((PROD_WIDTH > COEF_WIDTH + COORD_FRAC) ?
                                PROD_WIDTH : COEF_WIDTH + COORD_FRAC) + 2;

  localparam int NUM_PLANES = 6;
  localparam int PLANE_LEFT   = 0;
  localparam int PLANE_RIGHT  = 1;
  localparam int PLANE_BOTTOM = 2;
  localparam int PLANE_TOP    = 3;
  localparam int PLANE_NEAR   = 4;
  localparam int PLANE_FAR    = 5;

  localparam logic [2:0] OUTCOME_VISIBLE    = 3'd0;
  localparam logic [2:0] OUTCOME_EMPTY      = 3'd1;
  localparam logic [2:0] OUTCOME_PLANE_BASE = 3'd2;

  localparam logic [2:0] REG_ROW_X = 3'd0;
  localparam logic [2:0] REG_ROW_Y = 3'd1;
  localparam logic [2:0] REG_ROW_Z = 3'd2;
  localparam logic [2:0] REG_ROW_W = 3'd3;
  localparam logic [2:0] REG_DEPTH = 3'd4;

  localparam logic [ROW_WIDTH-1:0] ROW_X_RESET = 64'd4096;
  localparam logic [ROW_WIDTH-1:0] ROW_Y_RESET = 64'd268435456;
  localparam logic [ROW_WIDTH-1:0] ROW_Z_RESET = 64'd17592186044416;
  localparam logic [ROW_WIDTH-1:0] ROW_W_RESET = 64'd1152921504606846976;

  typedef logic signed [ELEM_WIDTH-1:0]  elem_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [DIST_WIDTH-1:0]  dist_t;

  // nx, ny, nz, d from the lowest index up
  typedef struct packed {
    logic [3:0][COEF_WIDTH-1:0] c;
  } plane_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] lo;
    logic [2:0][COORD_WIDTH-1:0] hi;
  } box_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

  // element bits that lie above the register read as zero
  function automatic elem_t get_elem(input logic [ROW_WIDTH-1:0] row, input int j);
    logic [ROW_PAD-1:0] padded;
    padded = ROW_PAD'(row);
    return elem_t'(padded[j*ELEM_WIDTH +: ELEM_WIDTH]);
  endfunction

endpackage

// ----- hw/rtl/frustum_box_cull_core.sv -----
// Frustum culling core: tests one axis-aligned box per clock, unless the
// output stalls, against the six clip planes formed from the configured
// view-projection matrix rows, and reports visible plus an outcome code
// (visible, empty box, or the first rejecting plane in the order left, right,
// bottom, top, near, far). A box enters every cycle while the output is not
// stalled and passes the four register stages (box capture, eighteen corner
// products, plane distance signs, outcome encode). Output backpressure stalls
// only the stages that are full, so bubbles are absorbed. The user must write
// the matrix rows and depth mode through the cfg port only while no box is in
// flight, not enforced here; plane coefficients follow in the next cycle.
`include "frustum_box_cull_core_defines.svh"

module frustum_box_cull_core
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, 16 bits each
  input  logic [95:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // visible, outcome[2:0], zero pad
  output logic [7:0]  out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [ROW_WIDTH-1:0] row_r [4];
  logic                 depth_r;
  elem_t                elem [4][4];
  plane_t               plane_nxt [NUM_PLANES];
  plane_t               plane_r [NUM_PLANES];

  logic      v1_r, v2_r, v3_r, v4_r;
  logic      adv1, adv2, adv3, adv4;
  stage_en_t en;
  box_t      box_in;
  logic      empty_nxt;
  box_t      box1_r;
  logic      empty1_r, empty2_r, empty3_r;
  logic [NUM_PLANES-1:0] neg;
  logic      visible_nxt, visible_r;
  logic [2:0] outcome_nxt, outcome_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= ROW_X_RESET;
      row_r[1] <= ROW_Y_RESET;
      row_r[2] <= ROW_Z_RESET;
      row_r[3] <= ROW_W_RESET;
      depth_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_X: row_r[0] <= cfg_data;
        REG_ROW_Y: row_r[1] <= cfg_data;
        REG_ROW_Z: row_r[2] <= cfg_data;
        REG_ROW_W: row_r[3] <= cfg_data;
        REG_DEPTH: depth_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // plane coefficients: w +/- row, near is z alone in zero-to-one mode
  always_comb begin
    for (int a = 0; a < 4; a++) begin
      for (int j = 0; j < 4; j++) begin
        elem[a][j] = get_elem(row_r[a], j);
      end
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int j = 0; j < 4; j++) begin
        if (p == PLANE_NEAR && depth_r) begin
          plane_nxt[p].c[j] = COEF_WIDTH'(elem[2][j]);
        end else if ((p & 1) == 1) begin
          plane_nxt[p].c[j] = COEF_WIDTH'(elem[3][j]) - COEF_WIDTH'(elem[p >> 1][j]);
        end else begin
          plane_nxt[p].c[j] = COEF_WIDTH'(elem[3][j]) + COEF_WIDTH'(elem[p >> 1][j]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      plane_r[p] <= plane_nxt[p];
    end
  end

  // stage advance, a stage moves when empty or when its successor moves
  assign adv4 = !v4_r || out_tready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_tready = adv1;
  assign en.s2 = adv2;
  assign en.s3 = adv3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_tvalid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  // stage 1: box capture and empty check
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      box_in.lo[a] = in_tdata[a*COORD_WIDTH +: COORD_WIDTH];
      box_in.hi[a] = in_tdata[(a+3)*COORD_WIDTH +: COORD_WIDTH];
    end
    empty_nxt = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (coord_t'(box_in.lo[a]) > coord_t'(box_in.hi[a])) empty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      box1_r   <= box_in;
      empty1_r <= empty_nxt;
    end
    if (adv2) empty2_r <= empty1_r;
    if (adv3) empty3_r <= empty2_r;
  end

  // stages 2 and 3: per-plane products and distance sign
  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    fbc_plane_dist u_dist (
      .clk   (clk),
      .en    (en),
      .plane (plane_r[p]),
      .box   (box1_r),
      .neg_r (neg[p])
    );
  end

  // stage 4: first rejecting test wins
  always_comb begin
    visible_nxt = 1'b1;
    outcome_nxt = OUTCOME_VISIBLE;
    if (empty3_r) begin
      visible_nxt = 1'b0;
      outcome_nxt = OUTCOME_EMPTY;
    end else begin
      for (int p = NUM_PLANES - 1; p >= 0; p--) begin
        if (neg[p]) begin
          visible_nxt = 1'b0;
          outcome_nxt = OUTCOME_PLANE_BASE + 3'(p);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      visible_r <= visible_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'b0000, outcome_r, visible_r};

  `FBC_ASSERT_NOW(a_visible_code, v4_r, visible_r == (outcome_r == OUTCOME_VISIBLE), "visible flag disagrees with outcome")
  `FBC_ASSERT_NEXT(a_empty_capture, in_tvalid && in_tready && ($signed(in_tdata[15:0]) > $signed(in_tdata[63:48])), v1_r && empty1_r, "empty box not flagged at capture")
  `FBC_ASSERT_NEXT(a_s2_hold, v2_r && !adv3, v2_r && $stable(empty2_r), "stalled stage 2 lost its request")
  `FBC_ASSERT_NEXT(a_s3_move, v3_r && adv4, v4_r, "stage 3 request dropped on advance")

endmodule

// ----- hw/rtl/fbc_plane_dist.sv -----
module fbc_plane_dist
  import fbc_pkg::*;
(
  input  logic      clk,
  input  stage_en_t en,
  input  plane_t    plane,
  input  box_t      box,
  output logic      neg_r
);

  coord_t corner [3];
  prod_t  prod_nxt [3];
  prod_t  prod_r [3];
  coef_t  d_r;
  dist_t  dist_nxt;

  // p-vertex: max corner where the normal component is non-negative
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      corner[a]   = plane.c[a][COEF_WIDTH-1] ? coord_t'(box.lo[a]) : coord_t'(box.hi[a]);
      prod_nxt[a] = coef_t'(plane.c[a]) * corner[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= prod_nxt[a];
      end
      d_r <= coef_t'(plane.c[3]);
    end
  end

  assign dist_nxt = DIST_WIDTH'(prod_r[0]) + DIST_WIDTH'(prod_r[1]) + DIST_WIDTH'(prod_r[2])
                  + (DIST_WIDTH'(d_r) <<< COORD_FRAC);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg_r <= dist_nxt[DIST_WIDTH-1];
    end
  end

endmodule
